// File: sv/pfe_pkg.sv
// Shared constants, types and the exponent chain program of the exponentiation unit.
package pfe_pkg;

  localparam int LIMB_COUNT = 4;
  localparam int LIMB_BITS  = 64;
  localparam int ELEM_BITS  = LIMB_COUNT * LIMB_BITS;

  // p = 5*2^248 - 1
  localparam logic [ELEM_BITS-1:0] MOD_P = {8'h04, {31{8'hff}}};

  localparam logic [1:0] OP_INV  = 2'd0;
  localparam logic [1:0] OP_SQRT = 2'd1;
  localparam logic [1:0] OP_SQT  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] LAST_LIMB = 2'(LIMB_COUNT - 1);

  typedef logic [2:0] slot_t;
  localparam slot_t SL_A   = 3'd0;
  localparam slot_t SL_Z4  = 3'd1;
  localparam slot_t SL_Z3  = 3'd2;
  localparam slot_t SL_T3  = 3'd3;
  localparam slot_t SL_T6  = 3'd4;
  localparam slot_t SL_ACC = 3'd5;
  localparam slot_t SL_TMP = 3'd6;
  localparam slot_t SL_ONE = 3'd7;

  typedef logic [4:0] pc_t;
  localparam pc_t PC_CHAIN = 5'd0;
  localparam pc_t PC_SQRT  = 5'd25;
  localparam pc_t PC_SQT   = 5'd28;

  typedef enum logic [1:0] {K_NEXT, K_FORK, K_DONE} kind_t;

  typedef struct packed {
    slot_t       dst;
    slot_t       sa;
    slot_t       sb;
    logic [7:0]  cnt;
    kind_t       kind;
  } ins_t;

  function automatic ins_t mk(slot_t d, slot_t a, slot_t b, logic [7:0] n, kind_t k);
    ins_t r;
    r.dst = d; r.sa = a; r.sb = b; r.cnt = n; r.kind = k;
    return r;
  endfunction

  // First pass of a step multiplies sa*sb into dst; repeats square dst.
  function automatic ins_t prog(pc_t pc);
    ins_t r;
    unique case (pc)
      5'd0:  r = mk(SL_Z4,  SL_A,   SL_A,   8'd1,   K_NEXT);
      5'd1:  r = mk(SL_Z3,  SL_A,   SL_Z4,  8'd1,   K_NEXT);
      5'd2:  r = mk(SL_Z4,  SL_Z4,  SL_Z4,  8'd1,   K_NEXT);
      5'd3:  r = mk(SL_T3,  SL_Z3,  SL_Z4,  8'd1,   K_NEXT);
      5'd4:  r = mk(SL_T6,  SL_T3,  SL_T3,  8'd3,   K_NEXT);
      5'd5:  r = mk(SL_T6,  SL_T6,  SL_T3,  8'd1,   K_NEXT);
      5'd6:  r = mk(SL_ACC, SL_T6,  SL_T6,  8'd6,   K_NEXT);
      5'd7:  r = mk(SL_ACC, SL_ACC, SL_T6,  8'd1,   K_NEXT);
      5'd8:  r = mk(SL_ACC, SL_ACC, SL_ACC, 8'd3,   K_NEXT);
      5'd9:  r = mk(SL_ACC, SL_ACC, SL_T3,  8'd1,   K_NEXT);
      5'd10: r = mk(SL_TMP, SL_ACC, SL_ACC, 8'd15,  K_NEXT);
      5'd11: r = mk(SL_ACC, SL_ACC, SL_TMP, 8'd1,   K_NEXT);
      5'd12: r = mk(SL_TMP, SL_ACC, SL_ACC, 8'd30,  K_NEXT);
      5'd13: r = mk(SL_ACC, SL_ACC, SL_TMP, 8'd1,   K_NEXT);
      5'd14: r = mk(SL_TMP, SL_ACC, SL_ACC, 8'd60,  K_NEXT);
      5'd15: r = mk(SL_ACC, SL_ACC, SL_TMP, 8'd1,   K_NEXT);
      5'd16: r = mk(SL_TMP, SL_ACC, SL_ACC, 8'd120, K_NEXT);
      5'd17: r = mk(SL_ACC, SL_ACC, SL_TMP, 8'd1,   K_NEXT);
      5'd18: r = mk(SL_ACC, SL_ACC, SL_ACC, 8'd6,   K_NEXT);
      5'd19: r = mk(SL_ACC, SL_ACC, SL_T6,  8'd1,   K_NEXT);
      5'd20: r = mk(SL_TMP, SL_ACC, SL_ACC, 8'd2,   K_NEXT);
      5'd21: r = mk(SL_ACC, SL_TMP, SL_ACC, 8'd1,   K_NEXT);
      5'd22: r = mk(SL_TMP, SL_ACC, SL_Z4,  8'd1,   K_FORK);
      5'd23: r = mk(SL_TMP, SL_TMP, SL_TMP, 8'd2,   K_NEXT);
      5'd24: r = mk(SL_TMP, SL_TMP, SL_A,   8'd1,   K_DONE);
      5'd25: r = mk(SL_TMP, SL_A,   SL_A,   8'd2,   K_NEXT);
      5'd26: r = mk(SL_TMP, SL_TMP, SL_A,   8'd1,   K_NEXT);
      5'd27: r = mk(SL_TMP, SL_TMP, SL_TMP, 8'd246, K_DONE);
      5'd28: r = mk(SL_TMP, SL_TMP, SL_TMP, 8'd1,   K_NEXT);
      5'd29: r = mk(SL_TMP, SL_TMP, SL_A,   8'd1,   K_NEXT);
      5'd30: r = mk(SL_TMP, SL_TMP, SL_ONE, 8'd1,   K_DONE);
      default: r = mk(SL_TMP, SL_TMP, SL_TMP, 8'd1, K_DONE);
    endcase
    return r;
  endfunction

endpackage

// File: sv/pfe_mont_mul.sv
// Word-serial Montgomery multiplier modulo p with one 32x32 multiplier.
module pfe_mont_mul import pfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ELEM_BITS-1:0] a_in,
  input  logic [ELEM_BITS-1:0] b_in,
  output logic                 done,
  output logic [ELEM_BITS-1:0] result
);

  localparam int TW = ELEM_BITS + 34;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t              state_r;
  logic [ELEM_BITS-1:0] a_r, b_r, res_r;
  logic [TW-1:0]        t_r;
  logic [63:0]          prod_r;
  logic [2:0]           i_r;
  logic [3:0]           ph_r;
  logic                 done_r;

  logic [2:0]    ph_m1;
  logic [TW-1:0] acc_add, red_add, t_sub;
  logic [34:0]   m5;

  assign ph_m1   = 3'(ph_r - 4'd1);
  assign acc_add = {{(TW-64){1'b0}}, prod_r} << {ph_m1, 5'b0};
  // t0*p = t0*5*2^248 - t0, so the reduction is a shift plus one add
  assign m5      = {3'b0, t_r[31:0]} + {1'b0, t_r[31:0], 2'b0};
  assign red_add = {{(TW-35){1'b0}}, m5} << 216;
  assign t_sub   = t_r - {{(TW-ELEM_BITS){1'b0}}, MOD_P};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      i_r     <= '0;
      ph_r    <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= a_in;
            b_r     <= b_in;
            t_r     <= '0;
            i_r     <= '0;
            ph_r    <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          if (ph_r < 4'd8) begin
            prod_r <= a_r[{ph_r[2:0], 5'b0} +: 32] * b_r[{i_r, 5'b0} +: 32];
          end
          if (ph_r == 4'd9) begin
            t_r  <= (t_r >> 32) + red_add;
            ph_r <= '0;
            i_r  <= 3'(i_r + 3'd1);
            if (i_r == 3'd7) state_r <= M_FIN;
          end else begin
            if (ph_r != 4'd0) t_r <= t_r + acc_add;
            ph_r <= 4'(ph_r + 4'd1);
          end
        end
        M_FIN: begin
          res_r   <= (t_r >= {{(TW-ELEM_BITS){1'b0}}, MOD_P}) ? t_sub[ELEM_BITS-1:0]
                                                             : t_r[ELEM_BITS-1:0];
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// File: sv/prime_field_exponentiation_unit.sv
// Top level: operand collection, chain sequencer, slot memory and result output.
// Exponentiation unit over p = 5*2^248-1 with Montgomery operands (R = 2^256).
// Send the four limbs of an operand, least significant first; the item with
// limb index 3 starts the operation named by op (inverse, square root or
// square test; op 3 only stores the limb). The block first subtracts p until
// the operand is reduced, then walks a fixed addition chain with one shared
// Montgomery multiplier. Each product runs 8 word passes through a single
// 32x32 multiplier, plus operand fetch, final correction and write-back into
// an 8-slot working memory. Inverse and square test run 262 products, square
// root 249. in_ready is low from the starting item until the last result
// item is taken. Inverse and square root return four result items with
// out_index 0..3 and out_last on the fourth; square test returns one item
// with a zero limb and the flag in out_square_flag.
module prime_field_exponentiation_unit import pfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_limb_index,
  input  logic [63:0] in_operand_limb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_limb,
  output logic [1:0]  out_index,
  output logic        out_square_flag,
  output logic        out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_RED, S_ONE, S_FETCH, S_START, S_WAIT, S_OUT
  } state_t;

  state_t               state_r;
  logic [63:0]          store_r [LIMB_COUNT];
  logic [ELEM_BITS-1:0] x_r, res_r, rd_a_r, rd_b_r;
  logic [ELEM_BITS-1:0] mem [8];
  logic [1:0]           op_r, oidx_r;
  pc_t                  pc_r;
  logic                 first_r;
  logic [7:0]           cnt_r;

  ins_t                 ins;
  slot_t                ra, rb, wa;
  logic                 we;
  logic [ELEM_BITS-1:0] wd, mul_res;
  logic                 mul_done, in_acc, out_acc, is_sqt;

  assign ins     = prog(pc_r);
  assign ra      = first_r ? ins.sa : ins.dst;
  assign rb      = first_r ? ins.sb : ins.dst;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign is_sqt  = (op_r == OP_SQT);

  pfe_mont_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_START),
    .a_in   (rd_a_r),
    .b_in   (rd_b_r),
    .done   (mul_done),
    .result (mul_res)
  );

  // Slot memory write: reduced operand, constant one, then each product.
  always_comb begin
    we = 1'b0;
    wa = SL_A;
    wd = x_r;
    unique case (state_r)
      S_RED:  we = (x_r < MOD_P);
      S_ONE:  begin we = 1'b1; wa = SL_ONE; wd = {{(ELEM_BITS-1){1'b0}}, 1'b1}; end
      S_WAIT: begin we = mul_done; wa = ins.dst; wd = mul_res; end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= PC_CHAIN;
      first_r <= 1'b1;
      cnt_r   <= '0;
      oidx_r  <= '0;
      op_r    <= OP_INV;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            store_r[in_limb_index] <= in_operand_limb;
            if (in_limb_index == LAST_LIMB && in_op != OP_NONE) begin
              op_r    <= in_op;
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          x_r     <= {store_r[3], store_r[2], store_r[1], store_r[0]};
          state_r <= S_RED;
        end
        S_RED: begin
          // subtract p until reduced; the write above takes the final value
          if (x_r >= MOD_P) x_r <= x_r - MOD_P;
          else state_r <= S_ONE;
        end
        S_ONE: begin
          pc_r    <= (op_r == OP_SQRT) ? PC_SQRT : PC_CHAIN;
          first_r <= 1'b1;
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          if (first_r) cnt_r <= ins.cnt;
          state_r <= S_START;
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            if (cnt_r != 8'd1) begin
              cnt_r   <= 8'(cnt_r - 8'd1);
              first_r <= 1'b0;
              state_r <= S_FETCH;
            end else begin
              first_r <= 1'b1;
              unique case (ins.kind)
                K_NEXT: begin pc_r <= 5'(pc_r + 5'd1); state_r <= S_FETCH; end
                K_FORK: begin
                  pc_r    <= is_sqt ? PC_SQT : 5'(pc_r + 5'd1);
                  state_r <= S_FETCH;
                end
                K_DONE: begin
                  res_r   <= mul_res;
                  oidx_r  <= '0;
                  state_r <= S_OUT;
                end
                default: state_r <= S_FETCH;
              endcase
            end
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (is_sqt || oidx_r == LAST_LIMB) state_r <= S_IDLE;
            else oidx_r <= 2'(oidx_r + 2'd1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_result_limb = is_sqt ? 64'd0 : res_r[{oidx_r, 6'b0} +: 64];
  assign out_index       = is_sqt ? 2'd0 : oidx_r;
  assign out_square_flag = is_sqt && (res_r == {{(ELEM_BITS-1){1'b0}}, 1'b1});
  assign out_last        = is_sqt || (oidx_r == LAST_LIMB);

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_WAIT) else $error("product finished outside wait");
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open while result pending");
  a_sqt_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && is_sqt) |-> (out_last && out_index == 2'd0 && out_result_limb == 64'd0))
    else $error("square test item malformed");
  a_out_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_WAIT) else $error("result without chain end");

endmodule

// File: bench/tb_prime_field_exponentiation_unit.sv
// Self-checking testbench for the prime field exponentiation unit.
module tb_prime_field_exponentiation_unit;
  import pfe_pkg::*;

  typedef logic [ELEM_BITS-1:0] elem_t;

  // One expected result item.
  typedef struct {
    logic [63:0] limb;
    logic [1:0]  index;
    logic        flag;
    logic        last;
  } limb_result_t;

  // Predict results from accepted limbs and compare the result items.
  class exp_scoreboard;
    elem_t        slots [LIMB_COUNT];
    limb_result_t pending [$];
    elem_t        one_mont;
    int           mismatches;
    int           results_seen;
    int           ops_started;
    int           sqt_hits;

    function new();
      logic [ELEM_BITS:0] x;
      x = {1'b1, {ELEM_BITS{1'b0}}};
      while (x >= {1'b0, MOD_P}) x = x - {1'b0, MOD_P};
      one_mont = x[ELEM_BITS-1:0];
      mismatches = 0;
      results_seen = 0;
      ops_started = 0;
      sqt_hits = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    // Montgomery product a*b/2^256 mod p, word-serial reduction.
    function elem_t mont_mul(elem_t a, elem_t b);
      logic [2*ELEM_BITS+7:0] t;
      logic [2*ELEM_BITS+7:0] m;
      t = {8'd0, ELEM_BITS'(0), a} * {8'd0, ELEM_BITS'(0), b};
      for (int i = 0; i < 8; i++) begin
        m = {{(2*ELEM_BITS-24){1'b0}}, t[31:0]};
        t = (t + m * {8'd0, ELEM_BITS'(0), MOD_P}) >> 32;
      end
      if (t >= {8'd0, ELEM_BITS'(0), MOD_P}) t = t - {8'd0, ELEM_BITS'(0), MOD_P};
      return t[ELEM_BITS-1:0];
    endfunction

    function elem_t mont_pow(elem_t a, elem_t e);
      elem_t r;
      r = one_mont;
      for (int i = ELEM_BITS - 1; i >= 0; i--) begin
        r = mont_mul(r, r);
        if (e[i]) r = mont_mul(r, a);
      end
      return r;
    endfunction

    // Store the limb; on the top limb with a real op, queue what it yields.
    function void note_limb(logic [1:0] op, logic [1:0] idx, logic [63:0] limb);
      elem_t a, r;
      limb_result_t e;
      slots[idx] = {192'd0, limb};
      if (idx != LAST_LIMB || op == OP_NONE) return;
      ops_started++;
      a = slots[0] | (slots[1] << 64) | (slots[2] << 128) | (slots[3] << 192);
      while (a >= MOD_P) a = a - MOD_P;
      if (op == OP_SQT) begin
        r = mont_mul(mont_pow(a, (MOD_P - 1) >> 1), ELEM_BITS'(1));
        e.limb = '0; e.index = '0; e.flag = (r == ELEM_BITS'(1)); e.last = 1'b1;
        if (e.flag) sqt_hits++;
        pending.push_back(e);
        return;
      end
      if (op == OP_INV) r = mont_pow(a, MOD_P - 2);
      else r = mont_pow(a, (MOD_P + 1) >> 2);
      for (int i = 0; i < LIMB_COUNT; i++) begin
        e.limb = r[64*i +: 64]; e.index = 2'(i); e.flag = 1'b0;
        e.last = (i == LIMB_COUNT - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_limb(logic [63:0] limb, logic [1:0] idx, logic flag, logic last);
      limb_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: limb %h index %0d", limb, idx);
        return;
      end
      e = pending.pop_front();
      if (limb !== e.limb || idx !== e.index || flag !== e.flag || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp limb %h idx %0d flag %0b last %0b, got %h %0d %0b %0b",
                   e.limb, e.index, e.flag, e.last, limb, idx, flag, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = OP_INV;
  logic [1:0]  in_limb_index = '0;
  logic [63:0] in_operand_limb = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_limb;
  logic [1:0]  out_index;
  logic        out_square_flag;
  logic        out_last;

  prime_field_exponentiation_unit dut (.*);

  always #5 clk = ~clk;

  exp_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int cycles = 0;
  int items_sent = 0;
  localparam int CYCLE_LIMIT = 30000000;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every accepted result item.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_limb(out_result_limb, out_index, out_square_flag, out_last);
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_prime_field_exponentiation_unit failed");
      $finish;
    end
  end

  // Offer one item, holding it until the block takes it.
  task automatic send_limb(logic [1:0] op, logic [1:0] idx, logic [63:0] limb);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_limb_index <= idx;
    in_operand_limb <= limb;
    do @(posedge clk); while (!in_ready);
    sb.note_limb(op, idx, limb);
    items_sent++;
  endtask

  task automatic send_elem(logic [1:0] op, elem_t a);
    for (int i = 0; i < LIMB_COUNT; i++) send_limb(op, 2'(i), a[64*i +: 64]);
  endtask

  // Pick an operand: mostly random, with zero, p, p-1, all ones and small values mixed in.
  function automatic elem_t pick_elem();
    elem_t a;
    a = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(9))
      0: a = '0;
      1: a = MOD_P;
      2: a = MOD_P - 1;
      3: a = '1;
      4: a = ELEM_BITS'($urandom_range(5));
      5: a = sb.one_mont;
      6, 7: a[255:248] = 8'($urandom_range(4));
      default: ;
    endcase
    return a;
  endfunction

  task automatic random_phase(int idle, int stall, int count);
    int start;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 85) begin
        send_elem(2'($urandom_range(2)), pick_elem());
      end else begin
        // Noise: a stray limb in any slot, any op including the unused one.
        send_limb(2'($urandom_range(3)), 2'($urandom_range(3)),
                  {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero, unreduced operands, extremes, unused op, out-of-order limbs.
    send_elem(OP_INV, '0);
    send_elem(OP_SQRT, MOD_P);
    send_limb(OP_SQT, LAST_LIMB, 64'h0);
    send_elem(OP_INV, '1);
    send_limb(OP_SQRT, LAST_LIMB, 64'hffff_ffff_ffff_ffff);
    send_limb(OP_SQT, LAST_LIMB, 64'h04ff_ffff_ffff_ffff);
    send_limb(OP_NONE, LAST_LIMB, 64'h0123_4567_89ab_cdef);
    send_limb(OP_NONE, 2'd1, 64'h5555_aaaa_5555_aaaa);
    send_limb(OP_SQT, LAST_LIMB, 64'h0000_0000_0000_0001);
    send_elem(OP_INV, sb.one_mont);
    send_limb(OP_INV, 2'd2, 64'haaaa_5555_aaaa_5555);
    send_limb(OP_SQRT, 2'd0, 64'h1);
    send_limb(OP_SQT, LAST_LIMB, 64'h0200_0000_0000_0000);

    // Hold the receiver off for longer than one operation so the input backs up.
    hold_off = 40000;
    random_phase(0, 0, 60);
    random_phase(67, 0, 60);
    random_phase(0, 67, 60);
    random_phase(36, 36, 60);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d limb items, started %0d operations, checked %0d result items",
             items_sent, sb.ops_started, sb.results_seen);
    $display("square test found %0d squares; %0d mismatches", sb.sqt_hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_prime_field_exponentiation_unit passed");
    end else begin
      $display("tb_prime_field_exponentiation_unit failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pfe_pkg.sv
sv/pfe_mont_mul.sv
sv/prime_field_exponentiation_unit.sv
bench/tb_prime_field_exponentiation_unit.sv
